@@ hdl/line_height_anomaly_scanner_top_macros.svh @@
// Assertion macros for the line height anomaly scanner
`ifndef LINE_HEIGHT_ANOMALY_SCANNER_TOP_MACROS_SVH
`define LINE_HEIGHT_ANOMALY_SCANNER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define LHAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define LHAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/lhas_pkg.sv @@
// Shared constants, types and codes of the line height anomaly scanner
package lhas_pkg;

	localparam int LINE_MAX = 64;
	localparam int ADDR_W = $clog2(LINE_MAX);
	localparam int CNT_W = $clog2(LINE_MAX + 1);
	localparam int H_W = 32;
	localparam int POS_W = 6;
	localparam int CFG_W = 31;
	localparam int SUM_W = H_W + ADDR_W;
	localparam int THR_W = CFG_W + ADDR_W;
	localparam int CMP_W = THR_W + 1;
	localparam int IN_TDATA_W = 32;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_PAD_W = OUT_TDATA_W - POS_W - H_W;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_W-1:0] RISE_RESET = CFG_W'(1024);
	localparam logic [CFG_W-1:0] DROP_RESET = CFG_W'(1024);
	localparam logic [CFG_W-1:0] ALLOW_RESET = CFG_W'(1024);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RISE,
		CFG_DROP,
		CFG_ALLOW,
		CFG_REVERSE
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_READ,
		ST_MUL,
		ST_EVAL
	} lhas_state_t;

	typedef struct packed {
		logic start;
		logic mul_en;
		logic fire;
	} lhas_ctl_t;

	typedef struct packed {
		logic abnormal;
		logic [H_W-1:0] ref_height;
	} lhas_res_t;

endpackage

@@ hdl/line_height_anomaly_scanner_top.sv @@
// Line height anomaly scanner: line loading, scan sequencing and result register
//
// Samples arrive on the s_ stream, one per cycle while s_tready is high; tlast
// marks the last sample of a line. Up to LINE_MAX samples are stored and summed;
// further samples of the same line are dropped, but a dropped tlast still ends
// the line. At the end of a line s_tready falls and the stored samples are
// scanned, forward or reversed, giving one result per stored sample on m_.
// After the tlast transfer the first sample is read from the line store, its
// product registered, then its result registered in the classification step;
// each later sample's read is issued as the result before it is registered.
// While a result waits and m_tready is low the result register holds and the
// scan pauses in the classification step; s_tready rises as the last result
// is registered, and that result may still wait to be taken. Configuration
// writes on cfg_we take effect at once; the user must make them while idle,
// as the block does not enforce it. Reset clears sequencer, counts, sum, settings
// and m_tvalid; the line store is not cleared and needs no clearing pass.
`include "line_height_anomaly_scanner_top_macros.svh"

module line_height_anomaly_scanner_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [lhas_pkg::IN_TDATA_W-1:0]      s_tdata,  // height[31:0]
	input  logic                                 s_tlast,  // last_in_line
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [lhas_pkg::OUT_TDATA_W-1:0]     m_tdata,  // position[5:0], reference_height[37:6], zero
	output logic                                 m_tuser,  // abnormal
	output logic                                 m_tlast,  // last_result
	input  logic                                 cfg_we,
	input  logic [lhas_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [lhas_pkg::CFG_W-1:0]           cfg_data
);
	import lhas_pkg::*;

	lhas_state_t             state_q;
	lhas_state_t             state_d;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        n_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [ADDR_W-1:0]       pos_q;
	logic [ADDR_W-1:0]       remain_q;
	logic [CFG_W-1:0]        rise_q;
	logic [CFG_W-1:0]        drop_q;
	logic [CFG_W-1:0]        allow_q;
	logic                    reverse_q;

	logic                    m_valid_q;
	logic [ADDR_W-1:0]       m_pos_q;
	logic                    m_abn_q;
	logic [H_W-1:0]          m_ref_q;
	logic                    m_last_q;

	logic                    accept;
	logic                    store;
	logic                    fire;
	logic                    scan_done;
	logic [CNT_W-1:0]        n_new;
	logic [CNT_W-1:0]        n_m1;
	logic [ADDR_W-1:0]       pos_nx;
	logic signed [H_W-1:0]   height;
	logic                    ram_re;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [H_W-1:0]          ram_rdata;
	lhas_ctl_t               ctl;
	lhas_res_t               res;

	assign height = $signed(s_tdata[H_W-1:0]);
	assign accept = s_tvalid && s_tready;
	assign store = accept && (cnt_q < CNT_W'(LINE_MAX));
	assign n_new = cnt_q + CNT_W'(store);
	assign n_m1 = n_new - CNT_W'(1);
	assign pos_nx = reverse_q ? pos_q - ADDR_W'(1) : pos_q + ADDR_W'(1);
	assign scan_done = fire && (remain_q == '0);

	always_comb begin
		state_d = state_q;
		s_tready = 1'b0;
		fire = 1'b0;
		ram_re = 1'b0;
		ram_raddr = pos_q;
		ctl = '0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (accept && s_tlast) begin
					ctl.start = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ram_re = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				ctl.mul_en = 1'b1;
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				fire = !m_valid_q || m_tready;
				ctl.fire = fire;
				ram_re = fire;
				ram_raddr = pos_nx;
				if (fire) begin
					state_d = (remain_q == '0) ? ST_LOAD : ST_MUL;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q <= RISE_RESET;
			drop_q <= DROP_RESET;
			allow_q <= ALLOW_RESET;
			reverse_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_RISE:    rise_q <= cfg_data;
				CFG_DROP:    drop_q <= cfg_data;
				CFG_ALLOW:   allow_q <= cfg_data;
				CFG_REVERSE: reverse_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			n_q <= '0;
			sum_q <= '0;
			pos_q <= '0;
			remain_q <= '0;
		end else begin
			if (accept && s_tlast) begin
				cnt_q <= '0;
				n_q <= n_new;
				remain_q <= n_m1[ADDR_W-1:0];
				pos_q <= reverse_q ? n_m1[ADDR_W-1:0] : '0;
			end else if (store) begin
				cnt_q <= n_new;
			end else if (fire) begin
				pos_q <= pos_nx;
				remain_q <= remain_q - ADDR_W'(1);
			end
			if (scan_done) begin
				sum_q <= '0;
			end else if (store) begin
				sum_q <= sum_q + SUM_W'(height);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (fire) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_pos_q <= pos_q;
			m_abn_q <= res.abnormal;
			m_ref_q <= res.ref_height;
			m_last_q <= remain_q == '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata = {{OUT_PAD_W{1'b0}}, m_ref_q, POS_W'(m_pos_q)};
	assign m_tuser = m_abn_q;
	assign m_tlast = m_last_q;

	lhas_ram #(
		.WIDTH(H_W),
		.DEPTH(LINE_MAX)
	) u_line_store (
		.clk   (clk),
		.we    (store),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (s_tdata[H_W-1:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	lhas_eval u_eval (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.rdata    (ram_rdata),
		.n        (n_q),
		.line_sum (sum_q),
		.rise     (rise_q),
		.drop     (drop_q),
		.allow    (allow_q),
		.res      (res)
	);

	`LHAS_ASSERT_NEXT(a_done_reload, scan_done, s_tready, "scan end did not return to loading")
	`LHAS_ASSERT_NOW(a_ref_zero, m_tvalid && !m_tuser, m_tdata[H_W+POS_W-1:POS_W] == '0, "unflagged result carries a reference")
	`LHAS_ASSERT_NOW(a_cnt_cap, s_tready, cnt_q <= CNT_W'(LINE_MAX), "load count beyond line length")
	`LHAS_ASSERT_NEXT(a_stall_hold, state_q == ST_EVAL && !fire, state_q == ST_EVAL && $stable(pos_q), "stalled scan moved on")

endmodule

@@ hdl/lhas_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module lhas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/lhas_eval.sv @@
// Per-sample mean test, rise and drop classification and reference tracking
module lhas_eval (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lhas_pkg::lhas_ctl_t           ctl,
	input  logic [lhas_pkg::H_W-1:0]      rdata,
	input  logic [lhas_pkg::CNT_W-1:0]    n,
	input  logic signed [lhas_pkg::SUM_W-1:0] line_sum,
	input  logic [lhas_pkg::CFG_W-1:0]    rise,
	input  logic [lhas_pkg::CFG_W-1:0]    drop,
	input  logic [lhas_pkg::CFG_W-1:0]    allow,
	output lhas_pkg::lhas_res_t           res
);
	import lhas_pkg::*;

	logic signed [H_W-1:0]       cur_s2;
	logic signed [SUM_W-1:0]     prod_s2;
	logic signed [H_W+CNT_W:0]   mul_full;
	logic signed [H_W-1:0]       ref_q;
	logic [THR_W-1:0]            thr_q;
	logic                        seeded_q;

	logic signed [H_W-1:0]       ref_eff;
	logic [THR_W-1:0]            thr_eff;
	logic signed [CMP_W-1:0]     rise_d;
	logic signed [CMP_W-1:0]     fall_d;
	logic                        below;
	logic                        flag;
	logic                        ignore;
	logic                        update;

	assign mul_full = $signed(rdata) * $signed({1'b0, n});

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			cur_s2 <= $signed(rdata);
			prod_s2 <= mul_full[SUM_W-1:0];
		end
	end

	always_comb begin
		ref_eff = seeded_q ? ref_q : cur_s2;
		thr_eff = seeded_q ? thr_q : THR_W'(rise);
		rise_d = CMP_W'(cur_s2) - CMP_W'(ref_eff);
		fall_d = CMP_W'(ref_eff) - CMP_W'(cur_s2);
		below = !seeded_q && (prod_s2 < line_sum);
		flag = !below && (rise_d > $signed({1'b0, thr_eff}));
		ignore = !below && !flag
			&& (fall_d > $signed({{(CMP_W - CFG_W){1'b0}}, drop}));
		update = !below && !flag && !ignore;
		res.abnormal = flag;
		res.ref_height = flag ? ref_eff : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= '0;
			thr_q <= '0;
			seeded_q <= 1'b0;
		end else if (ctl.start) begin
			thr_q <= THR_W'(rise);
			seeded_q <= 1'b0;
		end else if (ctl.fire) begin
			if (flag) begin
				thr_q <= thr_eff + THR_W'(allow);
			end else if (update) begin
				ref_q <= cur_s2;
				thr_q <= THR_W'(rise);
				seeded_q <= 1'b1;
			end
		end
	end

endmodule

@@ verif/line_height_anomaly_scanner_top_test.sv @@
// Self-checking regression bench for the line height anomaly scanner
`timescale 1ns / 100ps

typedef struct {
	logic [lhas_pkg::POS_W-1:0] position;
	logic                       abnormal;
	logic [lhas_pkg::H_W-1:0]   ref_height;
	logic                       last;
} flag_result_t;

class height_flag_board;
	logic [lhas_pkg::CFG_W-1:0] rise_reg = lhas_pkg::RISE_RESET;
	logic [lhas_pkg::CFG_W-1:0] drop_reg = lhas_pkg::DROP_RESET;
	logic [lhas_pkg::CFG_W-1:0] allow_reg = lhas_pkg::ALLOW_RESET;
	bit                         reverse_reg = 1'b0;
	longint                     line_heights [lhas_pkg::LINE_MAX];
	longint                     line_total = 0;
	int                         line_count = 0;
	longint                     ref_level = 0;
	flag_result_t               pending [$];
	int                         errors = 0;

	function void set_reg(lhas_pkg::cfg_idx_t idx, logic [lhas_pkg::CFG_W-1:0] val);
		case (idx)
			lhas_pkg::CFG_RISE:    rise_reg = val;
			lhas_pkg::CFG_DROP:    drop_reg = val;
			lhas_pkg::CFG_ALLOW:   allow_reg = val;
			lhas_pkg::CFG_REVERSE: reverse_reg = val[0];
			default: ;
		endcase
	endfunction

	// append one expected result
	function void queue_result(flag_result_t r);
		pending = {pending, r};
	endfunction

	// store and sum the sample, then scan the line when it closes
	function void take_sample(logic [lhas_pkg::H_W-1:0] h, logic last);
		longint n;
		longint cur;
		longint allowance;
		int run;
		int pos;
		bit seeded;
		flag_result_t r;
		if (line_count < lhas_pkg::LINE_MAX) begin
			line_heights[line_count] = longint'($signed(h));
			line_total += longint'($signed(h));
			line_count++;
		end
		if (!last)
			return;
		n = line_count;
		seeded = 1'b0;
		run = 0;
		for (int i = 0; i < n; i++) begin
			pos = reverse_reg ? int'(n - 1 - i) : i;
			cur = line_heights[pos];
			r.position = pos[lhas_pkg::POS_W-1:0];
			r.abnormal = 1'b0;
			r.ref_height = '0;
			r.last = (i == n - 1);
			if (!seeded && cur * n < line_total) begin
				queue_result(r);
				continue;
			end
			if (!seeded) begin
				ref_level = cur;
				seeded = 1'b1;
			end
			allowance = longint'(allow_reg) * run;
			if (cur - ref_level - allowance > longint'(rise_reg)) begin
				r.abnormal = 1'b1;
				r.ref_height = ref_level[lhas_pkg::H_W-1:0];
				if (run < 63)
					run++;
			end else if (ref_level - cur > longint'(drop_reg)) begin
				// hold reference and run on an ignored drop
			end else begin
				ref_level = cur;
				run = 0;
			end
			queue_result(r);
		end
		line_count = 0;
		line_total = 0;
	endfunction

	function void check_result(logic [lhas_pkg::OUT_TDATA_W-1:0] data, logic abn, logic last);
		flag_result_t e;
		logic [lhas_pkg::POS_W-1:0] got_pos;
		logic [lhas_pkg::H_W-1:0]   got_ref;
		logic [lhas_pkg::OUT_PAD_W-1:0] got_pad;
		got_pos = data[lhas_pkg::POS_W-1:0];
		got_ref = data[lhas_pkg::POS_W +: lhas_pkg::H_W];
		got_pad = data[lhas_pkg::OUT_TDATA_W-1 -: lhas_pkg::OUT_PAD_W];
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10)
				$display("unexpected result: pos %0d abn %0b ref %0d last %0b",
					got_pos, abn, $signed(got_ref), last);
			return;
		end
		e = pending.pop_front();
		if (got_pos !== e.position || abn !== e.abnormal || got_ref !== e.ref_height ||
				last !== e.last || got_pad !== '0) begin
			errors++;
			if (errors <= 10)
				$display("result mismatch: exp pos %0d abn %0b ref %0d last %0b | got pos %0d abn %0b ref %0d last %0b pad %0h",
					e.position, e.abnormal, $signed(e.ref_height), e.last,
					got_pos, abn, $signed(got_ref), last, got_pad);
		end
	endfunction
endclass

module line_height_anomaly_scanner_top_test;
	import lhas_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;  // height[31:0]
	logic                   s_tlast;  // last_in_line
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;  // position[5:0], reference_height[37:6], zero
	logic                   m_tuser;  // abnormal
	logic                   m_tlast;  // last_result
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	height_flag_board board;
	bit calm;
	bit long_hold;
	int sent;

	line_height_anomaly_scanner_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("line_height_anomaly_scanner_top regression: fail");
		$finish;
	end

	// result side: check each transfer, then pick the next tready
	initial begin
		int gap;
		gap = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_result(m_tdata, m_tuser, m_tlast);
			if (long_hold) begin
				long_hold = 1'b0;
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				m_tready <= 1'b1;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else if (gap > 0) begin
				gap--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 14) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	task automatic send_sample(logic [H_W-1:0] h, bit last);
		if (!calm && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= h;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		board.take_sample(h, last);
		sent++;
	endtask

	task automatic send_line(int hs[$]);
		foreach (hs[i])
			send_sample(hs[i], i == hs.size() - 1);
	endtask

	// mostly smooth terrain with rises, drops and flat stretches; some lines pure noise
	task automatic run_line(int len);
		int hs[$];
		longint lvl;
		longint scale;
		longint dscale;
		longint d;
		bit noisy;
		noisy = ($urandom_range(0, 5) == 0);
		scale = (board.rise_reg < 8) ? 8 : (board.rise_reg > (1 << 24)) ? (1 << 24) : board.rise_reg;
		dscale = (board.drop_reg < 8) ? 8 : (board.drop_reg > (1 << 24)) ? (1 << 24) : board.drop_reg;
		lvl = longint'(int'($urandom)) >>> $urandom_range(2, 10);
		for (int i = 0; i < len; i++) begin
			if (noisy) begin
				lvl = longint'(int'($urandom));
			end else begin
				case ($urandom_range(0, 10))
					0, 1, 2, 3, 4: d = longint'($urandom_range(0, 2 * scale)) - scale;
					5, 6: d = scale + $urandom_range(0, scale) +
						longint'(board.allow_reg) * $urandom_range(0, 2);
					7, 8: d = -(dscale + $urandom_range(1, dscale));
					9: d = longint'(int'($urandom)) - lvl;
					default: d = 0;
				endcase
				lvl += d;
				if (lvl > 64'sd2147483647)
					lvl = 64'sd2147483647;
				if (lvl < -64'sd2147483648)
					lvl = -64'sd2147483648;
			end
			hs = {hs, int'(lvl)};
		end
		send_line(hs);
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic load_settings(logic [CFG_W-1:0] rise, logic [CFG_W-1:0] drop,
			logic [CFG_W-1:0] allow, bit rev);
		cfg_idx_t order [4];
		logic [CFG_W-1:0] vals [4];
		order = '{CFG_RISE, CFG_DROP, CFG_ALLOW, CFG_REVERSE};
		vals = '{rise, drop, allow, CFG_W'(rev)};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= order[i];
			cfg_data <= vals[i];
			@(posedge clk);
			board.set_reg(order[i], vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	initial begin
		int quota [1:6];
		int len;
		logic [CFG_W-1:0] cfg_max;
		board = new();
		quota = '{45, 70, 160, 180, 198, 212};
		cfg_max = '1;
		calm = 1'b0;
		long_hold = 1'b0;
		sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b1;
		cfg_we = 1'b0;
		cfg_index = CFG_RISE;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: lone sample, extremes, skip, flag, run growth, drop, flat line
		send_line('{2147483647});
		send_line('{int'(32'h8000_0000), int'(32'h8000_0000), 2147483647, 2147483647});
		send_line('{-5000, 0, 100, 3000, 600, -2000, 4000, 5100, 2000});
		send_line('{7, 7, 7});
		send_line('{-3, 5000, 900, 7000});

		for (int ph = 1; ph <= 6; ph++) begin
			drain();
			case (ph)
				1: load_settings('0, '0, '0, 1'b1);
				2: load_settings(cfg_max, cfg_max, cfg_max, 1'b0);
				4: load_settings(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
					1'($urandom_range(0, 1)));
				default: load_settings(CFG_W'($urandom_range(0, 4096)),
					CFG_W'($urandom_range(0, 4096)), CFG_W'($urandom_range(0, 2048)),
					1'($urandom_range(0, 1)));
			endcase
			if (ph == 6)
				calm = 1'b1;
			if (ph == 1)
				send_line('{int'($urandom)});
			if (ph == 3) begin
				long_hold = 1'b1;
				run_line(8);
				run_line(5);
				// overlong line: the tail, tlast included, is dropped
				run_line(LINE_MAX + 3);
			end
			while (sent < quota[ph]) begin
				len = $urandom_range(1, 12);
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(13, 40);
				run_line(len);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0)
			$display("line_height_anomaly_scanner_top regression: pass");
		else
			$display("line_height_anomaly_scanner_top regression: fail");
		$finish;
	end

endmodule

@@ line_height_anomaly_scanner_top.f @@
+incdir+hdl
hdl/lhas_pkg.sv
hdl/lhas_ram.sv
hdl/lhas_eval.sv
hdl/line_height_anomaly_scanner_top.sv
verif/line_height_anomaly_scanner_top_test.sv
